### sv/dpec_pkg.sv
`default_nettype none
package dpec_pkg;

    typedef struct packed {
        logic [14:0]        first_pos_x;
        logic [14:0]        first_pos_y;
        logic signed [15:0] first_vel_x;
        logic signed [15:0] first_vel_y;
        logic [14:0]        second_pos_x;
        logic [14:0]        second_pos_y;
        logic signed [15:0] second_vel_x;
        logic signed [15:0] second_vel_y;
    } item_t;

    typedef struct packed {
        logic signed [15:0] new_first_vel_x;
        logic signed [15:0] new_first_vel_y;
        logic signed [15:0] new_second_vel_x;
        logic signed [15:0] new_second_vel_y;
        logic               collided;
    } result_t;

    typedef struct packed {
        logic signed [15:0] v1x;
        logic signed [15:0] v1y;
        logic signed [15:0] v2x;
        logic signed [15:0] v2y;
        logic               hit;
        logic               neg_x;
        logic               neg_y;
    } side_t;

    localparam int QW     = 17;
    localparam int NUMW   = 44;
    localparam int DENW   = 25;
    localparam int DIST2W = 24;
    localparam logic [7:0] DIAM_RESET = 8'd16;

endpackage
`default_nettype wire

### sv/dpec_div.sv
`default_nettype none
module dpec_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       valid_in,
    input  wire logic [dpec_pkg::NUMW-1:0]  num_x,
    input  wire logic [dpec_pkg::NUMW-1:0]  num_y,
    input  wire logic [dpec_pkg::DENW-1:0]  den,
    input  wire dpec_pkg::side_t            side_in,
    output logic                            valid_out,
    output logic [dpec_pkg::QW-1:0]         q_x,
    output logic [dpec_pkg::QW-1:0]         q_y,
    output dpec_pkg::side_t                 side_out
);
    import dpec_pkg::*;

    logic            valid_reg [QW];
    logic [NUMW-1:0] remx_reg  [QW];
    logic [NUMW-1:0] remy_reg  [QW];
    logic [QW-1:0]   qx_reg    [QW];
    logic [QW-1:0]   qy_reg    [QW];
    logic [DENW-1:0] den_reg   [QW];
    side_t           side_reg  [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        localparam int B = QW - 1 - g;
        logic            v_in;
        logic [NUMW-1:0] rx_in;
        logic [NUMW-1:0] ry_in;
        logic [QW-1:0]   qx_in;
        logic [QW-1:0]   qy_in;
        logic [DENW-1:0] d_in;
        side_t           s_in;
        logic [NUMW-1:0] dsh;
        logic            bx;
        logic            by;

        if (g == 0) begin : g_first
            assign v_in  = valid_in;
            assign rx_in = num_x;
            assign ry_in = num_y;
            assign qx_in = '0;
            assign qy_in = '0;
            assign d_in  = den;
            assign s_in  = side_in;
        end else begin : g_rest
            assign v_in  = valid_reg[g-1];
            assign rx_in = remx_reg[g-1];
            assign ry_in = remy_reg[g-1];
            assign qx_in = qx_reg[g-1];
            assign qy_in = qy_reg[g-1];
            assign d_in  = den_reg[g-1];
            assign s_in  = side_reg[g-1];
        end

        assign dsh = NUMW'(d_in) << B;
        assign bx  = (rx_in >= dsh);
        assign by  = (ry_in >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else
            begin
                valid_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            remx_reg[g] <= bx ? rx_in - dsh : rx_in;
            remy_reg[g] <= by ? ry_in - dsh : ry_in;
            qx_reg[g]   <= {qx_in[QW-2:0], bx};
            qy_reg[g]   <= {qy_in[QW-2:0], by};
            den_reg[g]  <= d_in;
            side_reg[g] <= s_in;
        end
    end

    assign valid_out = valid_reg[QW-1];
    assign q_x       = qx_reg[QW-1];
    assign q_y       = qy_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule
`default_nettype wire

### sv/disk_pair_elastic_collision.sv
// A start transaction passes through the front pipeline registers, the divider and the result register to done.
// Throughput: one disk pair per cycle; busy stays low, nothing stalls.
// The quotient comes from a 17-stage restoring divider, one bit per stage.
// rst_n (asynchronous, active low) empties the pipeline and sets the
// diameter register to 16; results cannot be held off by the receiver.
`default_nettype none
module disk_pair_elastic_collision (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire dpec_pkg::item_t   item,
    output logic                   done,
    output dpec_pkg::result_t      result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_data
);
    import dpec_pkg::*;

    logic [7:0] diam_reg;

    logic               v1_reg;
    logic signed [15:0] dx1_reg, dy1_reg;
    logic signed [16:0] rx1_reg, ry1_reg;
    side_t              s1_reg;

    logic               v2_reg;
    logic [31:0]        dx2_reg, dy2_reg;
    logic signed [29:0] rxdx2_reg, rydy2_reg;
    logic signed [12:0] dxs2_reg, dys2_reg;
    side_t              s2_reg;

    logic               v3_reg;
    logic [DIST2W-1:0]  dist3_reg;
    logic signed [30:0] dot3_reg;
    logic signed [12:0] dxs3_reg, dys3_reg;
    side_t              s3_reg;

    logic               v4_reg;
    logic signed [43:0] px4_reg, py4_reg;
    logic [DIST2W-1:0]  dist4_reg;
    side_t              s4_reg;

    logic               v5_reg;
    logic [NUMW-1:0]    nx5_reg, ny5_reg;
    logic [DENW-1:0]    den5_reg;
    side_t              s5_reg;

    logic               dv;
    logic [QW-1:0]      qx, qy;
    side_t              ds;

    logic               done_reg;
    result_t            result_reg;

    logic signed [16:0] rx_next, ry_next;
    logic signed [15:0] dx_next, dy_next;
    logic signed [31:0] sqx, sqy;
    logic [32:0]        dist_full;
    logic [23:0]        thresh;
    logic               hit_next;
    logic [43:0]        magx, magy;
    logic signed [17:0] cx, cy;
    logic signed [18:0] n1x, n1y, n2x, n2y;
    side_t              s3_next, s4_side, s5_next;

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767)
            return 16'sh7fff;
        else if (v < -19'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diam_reg <= DIAM_RESET;
        end
        else if (cfg_valid)
        begin
            diam_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= dv;
        end
    end

    always_comb
    begin
        dx_next   = $signed({1'b0, item.first_pos_x}) - $signed({1'b0, item.second_pos_x});
        dy_next   = $signed({1'b0, item.first_pos_y}) - $signed({1'b0, item.second_pos_y});
        rx_next   = 17'(item.first_vel_x) - 17'(item.second_vel_x);
        ry_next   = 17'(item.first_vel_y) - 17'(item.second_vel_y);
        sqx       = dx1_reg * dx1_reg;
        sqy       = dy1_reg * dy1_reg;
        dist_full = {1'b0, dx2_reg} + {1'b0, dy2_reg};
        thresh    = {8'(diam_reg * diam_reg) == 8'h00 && diam_reg == 8'h00 ? 16'h0000
                     : 16'(diam_reg * diam_reg), 8'h00};
        hit_next  = (dist_full < 33'(thresh)) && (dist_full != '0);
        s3_next     = s2_reg;
        s3_next.hit = hit_next;
        magx      = px4_reg[43] ? 44'(-px4_reg) : 44'(px4_reg);
        magy      = py4_reg[43] ? 44'(-py4_reg) : 44'(py4_reg);
        s4_side   = s4_reg;
        s5_next       = s4_side;
        s5_next.neg_x = px4_reg[43];
        s5_next.neg_y = py4_reg[43];
        cx  = ds.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        cy  = ds.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        n1x = 19'(ds.v1x) - 19'(cx);
        n1y = 19'(ds.v1y) - 19'(cy);
        n2x = 19'(ds.v2x) + 19'(cx);
        n2y = 19'(ds.v2y) + 19'(cy);
    end

    always_ff @(posedge clk)
    begin
        dx1_reg      <= dx_next;
        dy1_reg      <= dy_next;
        rx1_reg      <= rx_next;
        ry1_reg      <= ry_next;
        s1_reg.v1x   <= item.first_vel_x;
        s1_reg.v1y   <= item.first_vel_y;
        s1_reg.v2x   <= item.second_vel_x;
        s1_reg.v2y   <= item.second_vel_y;
        s1_reg.hit   <= 1'b0;
        s1_reg.neg_x <= 1'b0;
        s1_reg.neg_y <= 1'b0;

        dx2_reg   <= 32'(sqx);
        dy2_reg   <= 32'(sqy);
        rxdx2_reg <= 30'(rx1_reg * $signed(dx1_reg[12:0]));
        rydy2_reg <= 30'(ry1_reg * $signed(dy1_reg[12:0]));
        dxs2_reg  <= dx1_reg[12:0];
        dys2_reg  <= dy1_reg[12:0];
        s2_reg    <= s1_reg;

        dist3_reg <= dist_full[DIST2W-1:0];
        dot3_reg  <= 31'(rxdx2_reg) + 31'(rydy2_reg);
        dxs3_reg  <= dxs2_reg;
        dys3_reg  <= dys2_reg;
        s3_reg    <= s3_next;

        px4_reg   <= 44'(dot3_reg * dxs3_reg);
        py4_reg   <= 44'(dot3_reg * dys3_reg);
        dist4_reg <= dist3_reg;
        s4_reg    <= s3_reg;

        nx5_reg   <= (magx << 1) + NUMW'(dist4_reg);
        ny5_reg   <= (magy << 1) + NUMW'(dist4_reg);
        den5_reg  <= {dist4_reg, 1'b0};
        s5_reg    <= s5_next;

        if (ds.hit)
        begin
            result_reg.new_first_vel_x  <= sat16(n1x);
            result_reg.new_first_vel_y  <= sat16(n1y);
            result_reg.new_second_vel_x <= sat16(n2x);
            result_reg.new_second_vel_y <= sat16(n2y);
        end
        else
        begin
            result_reg.new_first_vel_x  <= ds.v1x;
            result_reg.new_first_vel_y  <= ds.v1y;
            result_reg.new_second_vel_x <= ds.v2x;
            result_reg.new_second_vel_y <= ds.v2y;
        end
        result_reg.collided <= ds.hit;
    end

    dpec_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v5_reg),
        .num_x     (nx5_reg),
        .num_y     (ny5_reg),
        .den       (den5_reg),
        .side_in   (s5_reg),
        .valid_out (dv),
        .q_x       (qx),
        .q_y       (qy),
        .side_out  (ds)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

### verif/disk_pair_elastic_collision_test.sv
`default_nettype none
module disk_pair_elastic_collision_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dpec_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 30;
    localparam int RANDOM_PER_PHASE = 90;

    class collision_scoreboard;
        logic [7:0] diameter;
        result_t    pending_results[$];
        int         mismatches;

        function new();
            diameter   = DIAM_RESET;
            mismatches = 0;
        endfunction

        function logic signed [15:0] clip16(longint v);
            if (v > 32767)
                return 16'sh7fff;
            if (v < -32768)
                return 16'sh8000;
            return v[15:0];
        endfunction

        function longint round_div(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q   = (2 * mag + den) / (2 * den);
            return (num < 0) ? -q : q;
        endfunction

        function result_t collide(item_t it);
            result_t r;
            longint dx, dy, dist2, limit, v1x, v1y, v2x, v2y, rx, ry, dot, cx, cy;
            v1x   = longint'(it.first_vel_x);
            v1y   = longint'(it.first_vel_y);
            v2x   = longint'(it.second_vel_x);
            v2y   = longint'(it.second_vel_y);
            dx    = longint'(it.first_pos_x) - longint'(it.second_pos_x);
            dy    = longint'(it.first_pos_y) - longint'(it.second_pos_y);
            dist2 = dx * dx + dy * dy;
            limit = (longint'(diameter) * longint'(diameter)) << 8;
            r.collided = 1'b0;
            if (dist2 < limit && dist2 != 0)
            begin
                rx  = v1x - v2x;
                ry  = v1y - v2y;
                dot = rx * dx + ry * dy;
                cx  = round_div(dot * dx, dist2);
                cy  = round_div(dot * dy, dist2);
                v1x = v1x - cx;
                v1y = v1y - cy;
                v2x = v2x + cx;
                v2y = v2y + cy;
                r.collided = 1'b1;
            end
            r.new_first_vel_x  = clip16(v1x);
            r.new_first_vel_y  = clip16(v1y);
            r.new_second_vel_x = clip16(v2x);
            r.new_second_vel_y = clip16(v2y);
            return r;
        endfunction

        function void note_pair(item_t it);
            pending_results.push_back(collide(it));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending_results.pop_front();
            if (got.new_first_vel_x !== want.new_first_vel_x
                || got.new_first_vel_y !== want.new_first_vel_y
                || got.new_second_vel_x !== want.new_second_vel_x
                || got.new_second_vel_y !== want.new_second_vel_y
                || got.collided !== want.collided)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected v1=(%0d,%0d) v2=(%0d,%0d) hit=%b,",
                              " got v1=(%0d,%0d) v2=(%0d,%0d) hit=%b"},
                             want.new_first_vel_x, want.new_first_vel_y,
                             want.new_second_vel_x, want.new_second_vel_y, want.collided,
                             got.new_first_vel_x, got.new_first_vel_y,
                             got.new_second_vel_x, got.new_second_vel_y, got.collided);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    item_t      item;
    logic       done;
    result_t    result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    collision_scoreboard sb;
    int idle_cycles = 0;

    disk_pair_elastic_collision i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (start && !busy)
            begin
                sb.note_pair(item);
            end
            if (done)
            begin
                sb.check_result(result);
            end
            if (cfg_valid && cfg_ready)
            begin
                sb.diameter = cfg_data;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("disk_pair_elastic_collision_test failed");
                $finish;
            end
        end
    end

    task automatic send_pair(item_t it);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles)
            @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_diameter(logic [7:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic item_t make_pair(int reach, logic [15:0] vsel);
        item_t it;
        int    margin;
        it.first_vel_x  = 16'($urandom);
        it.first_vel_y  = 16'($urandom);
        it.second_vel_x = 16'($urandom);
        it.second_vel_y = 16'($urandom);
        if (vsel[3:0] == 4'd0)
        begin
            it.first_vel_x  = 16'sh7fff;
            it.second_vel_x = 16'sh8000;
        end
        else if (vsel[3:0] == 4'd1)
        begin
            it.first_vel_y  = 16'sh8000;
            it.second_vel_y = 16'sh7fff;
        end
        if (reach == 0)
        begin
            it.first_pos_x  = 15'($urandom);
            it.first_pos_y  = 15'($urandom);
            it.second_pos_x = 15'($urandom);
            it.second_pos_y = 15'($urandom);
        end
        else
        begin
            margin = reach + 1;
            it.first_pos_x  = 15'($urandom_range(margin, 32767 - margin));
            it.first_pos_y  = 15'($urandom_range(margin, 32767 - margin));
            it.second_pos_x = 15'(int'(it.first_pos_x)
                                  + int'($urandom_range(0, 2 * reach)) - reach);
            it.second_pos_y = 15'(int'(it.first_pos_y)
                                  + int'($urandom_range(0, 2 * reach)) - reach);
            if (vsel[7:4] == 4'd0)
            begin
                it.second_pos_x = it.first_pos_x;
                it.second_pos_y = it.first_pos_y;
            end
        end
        return it;
    endfunction

    function automatic item_t pair_of(int p1x, int p1y, int v1x, int v1y,
                                      int p2x, int p2y, int v2x, int v2y);
        item_t it;
        it.first_pos_x  = 15'(p1x);
        it.first_pos_y  = 15'(p1y);
        it.first_vel_x  = 16'(v1x);
        it.first_vel_y  = 16'(v1y);
        it.second_pos_x = 15'(p2x);
        it.second_pos_y = 15'(p2y);
        it.second_vel_x = 16'(v2x);
        it.second_vel_y = 16'(v2y);
        return it;
    endfunction

    task automatic random_phase(int count, bit quiet);
        int reach;
        for (int n = 0; n < count; n++)
        begin
            reach = int'(sb.diameter) * 16;
            if ($urandom_range(0, 99) < 75)
                send_pair(make_pair(reach, 16'($urandom)));
            else
                send_pair(make_pair(0, 16'($urandom)));
            if (!quiet && $urandom_range(0, 99) < 19)
                pause_sender(1);
        end
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_pair(pair_of(0, 0, 0, 0, 32767, 32767, 0, 0));
        send_pair(pair_of(32767, 32767, 32767, -32768, 0, 0, -32768, 32767));
        send_pair(pair_of(1000, 1000, 256, 256, 1000, 1000, -256, 0));
        send_pair(pair_of(1000, 1000, 32767, 0, 900, 1000, -32768, 0));
        send_pair(pair_of(1000, 1000, 0, 32767, 1000, 900, 0, -32768));
        send_pair(pair_of(1000, 1000, 512, -300, 1256, 1000, 0, 0));
        send_pair(pair_of(1000, 1000, 512, -300, 1255, 1000, 0, 0));
        send_pair(pair_of(2000, 2000, -1000, 700, 2100, 2150, 300, -50));
        send_pair(pair_of(2000, 2000, -1, 1, 2001, 2001, 1, -1));
        send_pair(pair_of(21845, 10922, 21845, -21846, 21844, 10923, -21846, 21845));
        send_pair(pair_of(3000, 3000, 32767, 32767, 3010, 3010, -32768, -32768));

        write_diameter(8'd255);
        send_pair(pair_of(0, 0, 32767, 32767, 4079, 0, -32768, -32768));
        send_pair(pair_of(0, 0, 32767, 32767, 4080, 0, -32768, -32768));
        send_pair(pair_of(32767, 32767, 100, -100, 30000, 30000, -100, 100));
        random_phase(RANDOM_PER_PHASE, 1'b0);

        write_diameter(8'd1);
        send_pair(pair_of(500, 500, 32767, 0, 485, 500, -32768, 0));
        send_pair(pair_of(500, 500, 32767, 0, 484, 500, -32768, 0));
        random_phase(RANDOM_PER_PHASE, 1'b0);

        write_diameter(8'($urandom_range(2, 254)));
        random_phase(RANDOM_PER_PHASE, 1'b1);

        write_diameter(8'd80);
        random_phase(RANDOM_PER_PHASE, 1'b0);

        write_diameter(8'($urandom_range(1, 255)));
        random_phase(RANDOM_PER_PHASE, 1'b0);

        write_diameter(8'd16);
        random_phase(RANDOM_PER_PHASE, 1'b0);

        drain();
        if (sb.mismatches == 0)
            $display("disk_pair_elastic_collision_test passed");
        else
            $display("disk_pair_elastic_collision_test failed");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
sv/dpec_pkg.sv
sv/dpec_div.sv
sv/disk_pair_elastic_collision.sv
verif/disk_pair_elastic_collision_test.sv
